// File: rtl/mtg_pkg.sv
`default_nettype none
package mtg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [31:0] SEED_MULT    = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;
  localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK   = 32'h7FFF_FFFF;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] FAR_START = ADDR_W'(TWIST_OFFSET);

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic        we;
    addr_t       waddr;
    logic [31:0] wdata;
    logic        re_a;
    addr_t       raddr_a;
    logic        re_b;
    addr_t       raddr_b;
  } store_ctrl_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_FILL    = 7'b0000010,
    ST_TW_PRE  = 7'b0000100,
    ST_TW_PRE2 = 7'b0001000,
    ST_TWIST   = 7'b0010000,
    ST_READ    = 7'b0100000,
    ST_DELIVER = 7'b1000000
  } state_t;

  function automatic addr_t wrap_inc(input addr_t a);
    return (a == LAST_ADDR) ? '0 : addr_t'(a + 1'b1);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mtg_store.sv
`default_nettype none
module mtg_store
  import mtg_pkg::*;
(
  input  wire logic        clk,
  input  wire store_ctrl_t ctrl,
  output logic [31:0]      rd_a,
  output logic [31:0]      rd_b
);

  logic [31:0] mem [STATE_WORDS];

  // two read ports, one write port; reads see the value before a same-edge write
  always_ff @(posedge clk) begin
    if (ctrl.re_a) rd_a <= mem[ctrl.raddr_a];
    if (ctrl.re_b) rd_b <= mem[ctrl.raddr_b];
    if (ctrl.we) mem[ctrl.waddr] <= ctrl.wdata;
  end

endmodule
`default_nettype wire

// File: rtl/mtg_out_stage.sv
`default_nettype none
module mtg_out_stage
  import mtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [31:0] word,
  input  wire logic        fold_en,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [31:0]      random_word
);

  logic [31:0] tempered;
  logic [31:0] folded;

  // negating the most negative word gives it back unchanged
  always_comb begin
    tempered = temper(word);
    folded   = (fold_en && (tempered & UPPER_MASK) != '0) ? (~tempered + 32'd1) : tempered;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) random_word <= folded;
  end

endmodule
`default_nettype wire

// File: rtl/mersenne_twister_generator_core.sv
`default_nettype none
// a draw is accepted in ST_IDLE, read in ST_READ, loaded out in ST_DELIVER (which waits
// on a stalled result); no new request is taken before that load; a draw at word index
// 0 first twists the store (ST_TW_PRE, ST_TW_PRE2, ST_TWIST), one word per cycle through
// the two-read one-write store; a seed fills 624 words, one per cycle; a draw before any
// seed first fills them with the default seed; reset (synchronous, active high) clears
// control state and sets positive mode; store contents are undefined until the first fill
module mersenne_twister_generator_core
  import mtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      random_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        positive_mode
);

  state_t      state, state_next;
  addr_t       idx;
  addr_t       k;
  addr_t       ra;
  addr_t       rb;
  logic        seeded;
  logic        pending_draw;
  logic        fold_en;
  logic [31:0] x;
  logic [31:0] cur;
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic [31:0] mix;
  logic [31:0] twisted;
  logic        out_load;
  logic        in_xfer;
  store_ctrl_t ctrl;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  // rd_a holds the next word, rd_b the far word, cur the word being replaced
  always_comb begin
    mix     = (cur & UPPER_MASK) | (rd_a & LOWER_MASK);
    twisted = rd_b ^ (mix >> 1) ^ (rd_a[0] ? TWIST_MATRIX : 32'd0);
  end

  assign out_load = (state == ST_DELIVER) && (!out_valid || out_ready);

  always_comb begin
    ctrl       = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (operation == OP_SEED || !seeded) state_next = ST_FILL;
          else if (idx == '0)                 state_next = ST_TW_PRE;
          else                                state_next = ST_READ;
        end
      end
      ST_FILL: begin
        ctrl.we    = 1'b1;
        ctrl.waddr = k;
        ctrl.wdata = x;
        if (k == LAST_ADDR) state_next = pending_draw ? ST_TW_PRE : ST_IDLE;
      end
      ST_TW_PRE: begin
        ctrl.re_a    = 1'b1;
        ctrl.raddr_a = '0;
        state_next   = ST_TW_PRE2;
      end
      ST_TW_PRE2: begin
        ctrl.re_a    = 1'b1;
        ctrl.raddr_a = ra;
        ctrl.re_b    = 1'b1;
        ctrl.raddr_b = rb;
        state_next   = ST_TWIST;
      end
      ST_TWIST: begin
        ctrl.we      = 1'b1;
        ctrl.waddr   = k;
        ctrl.wdata   = twisted;
        ctrl.re_a    = 1'b1;
        ctrl.raddr_a = ra;
        ctrl.re_b    = 1'b1;
        ctrl.raddr_b = rb;
        if (k == LAST_ADDR) state_next = ST_READ;
      end
      ST_READ: begin
        ctrl.re_a    = 1'b1;
        ctrl.raddr_a = idx;
        state_next   = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      k            <= '0;
      seeded       <= 1'b0;
      pending_draw <= 1'b0;
      fold_en      <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) fold_en <= positive_mode;
      case (state)
        ST_IDLE: begin
          k <= '0;
          if (in_xfer) pending_draw <= (operation == OP_DRAW);
        end
        ST_FILL: begin
          k <= wrap_inc(k);
          if (k == LAST_ADDR) begin
            idx    <= '0;
            seeded <= 1'b1;
          end
        end
        ST_TW_PRE2: k <= '0;
        ST_TWIST:   k <= wrap_inc(k);
        ST_READ:    idx <= wrap_inc(idx);
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) x <= ((operation == OP_SEED) ? seed_value : DEFAULT_SEED) | 32'd1;
      end
      ST_FILL:  x <= 32'(x * SEED_MULT);
      ST_TW_PRE: begin
        ra <= wrap_inc('0);
        rb <= FAR_START;
      end
      ST_TW_PRE2: begin
        cur <= rd_a;
        ra  <= wrap_inc(ra);
        rb  <= wrap_inc(rb);
      end
      ST_TWIST: begin
        cur <= rd_a;
        ra  <= wrap_inc(ra);
        rb  <= wrap_inc(rb);
      end
      default: ;
    endcase
  end

  mtg_store u_store (
    .clk  (clk),
    .ctrl (ctrl),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  mtg_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (out_load),
    .word        (rd_a),
    .fold_en     (fold_en),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .random_word (random_word)
  );

endmodule
`default_nettype wire

// File: rtl/mtg_checker.sv
`default_nettype none
module mtg_checker
  import mtg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] random_word
);

  // a held result keeps its value until the transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(random_word))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // every accepted transaction makes the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // a reseed never produces a result: one accepted while no result is held leaves out_valid low
  a_seed_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_SEED && !out_valid |=> !out_valid)
    else $error("reseed produced a result");

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .operation   (operation),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .random_word (random_word)
);
`default_nettype wire
